// ----- rtl/sst_pkg.sv -----
package sst_pkg;

    localparam int TAG_W    = 32;
    localparam int POINTS_W = 16;
    localparam int TIME_W   = 16;
    localparam int RANK_W   = 5;

    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    tag;
        logic [POINTS_W-1:0] points;
        logic [TIME_W-1:0]   time_s;
    } sst_entry_t;

endpackage

// ----- rtl/sst_cell.sv -----
module sst_cell
    import sst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  sst_entry_t new_entry,
    input  sst_entry_t left_entry,
    input  logic       left_outranks,
    output sst_entry_t entry,
    output logic       outranks
);

    logic                valid_reg;
    logic                valid_next;
    logic [TAG_W-1:0]    tag_reg;
    logic [TAG_W-1:0]    tag_next;
    logic [POINTS_W-1:0] points_reg;
    logic [POINTS_W-1:0] points_next;
    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W-1:0]   time_next;

    // strictly ahead of the word being inserted
    assign outranks = valid_reg &&
        ((points_reg != new_entry.points) ? (points_reg > new_entry.points)
                                          : (time_reg < new_entry.time_s));

    always_comb
    begin
        valid_next  = valid_reg;
        tag_next    = tag_reg;
        points_next = points_reg;
        time_next   = time_reg;
        if (load && !outranks)
        begin
            if (left_outranks)
            begin
                valid_next  = 1'b1;
                tag_next    = new_entry.tag;
                points_next = new_entry.points;
                time_next   = new_entry.time_s;
            end
            else
            begin
                valid_next  = left_entry.valid;
                tag_next    = left_entry.tag;
                points_next = left_entry.points;
                time_next   = left_entry.time_s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg    <= tag_next;
        points_reg <= points_next;
        time_reg   <= time_next;
    end

    assign entry.valid  = valid_reg;
    assign entry.tag    = tag_reg;
    assign entry.points = points_reg;
    assign entry.time_s = time_reg;

endmodule

// ----- rtl/sorted_score_table_insert.sv -----
// Sorted score table, insert only.
// A word (tag, points, time_s) is taken at a rising edge with start high and
// busy low. busy is always low: a new word may follow in every cycle.
// The table is a row of TABLE_DEPTH cells. Every cell compares its entry with
// the incoming keys in the accept cycle; cells that do not outrank it either
// load the new word or take their left neighbor's entry, so the whole table
// is updated at the accept edge and the next word sees it.
// Ordering: points descending, then time ascending; a new word goes ahead of
// entries tied on both keys. When full, the last entry falls off, or the new
// word is dropped if it ranks last.
// Result: done is high for one cycle, after the accept edge has passed the
// compare stage and the rank encode stage, with rank (0 is top, TABLE_DEPTH
// low 5 bits if not placed) and dropped. One result per word, in order. The
// receiver cannot stall, results are never held.
// Reset clears all valid bits and the result pipeline; the table is empty.
module sorted_score_table_insert
    import sst_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [TAG_W-1:0]    tag,
    input  logic [POINTS_W-1:0] points,
    input  logic [TIME_W-1:0]   time_s,
    output logic                done,
    output logic [RANK_W-1:0]   rank,
    output logic                dropped
);

    localparam int IDX_W = $clog2(TABLE_DEPTH + 1);

    sst_entry_t                 new_entry;
    sst_entry_t                 cell_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]     cell_out;
    logic [TABLE_DEPTH-1:0]     cell_vld;
    logic [TABLE_DEPTH:0]       hot;
    logic                       load;

    logic                       s1_valid_reg;
    logic [TABLE_DEPTH:0]       hot_reg;
    logic                       full_reg;
    logic [IDX_W-1:0]           idx;
    logic                       done_reg;
    logic [RANK_W-1:0]          rank_reg;
    logic [RANK_W-1:0]          rank_next;
    logic                       dropped_reg;

    assign busy = 1'b0;
    assign load = start && !busy;

    assign new_entry.valid  = 1'b1;
    assign new_entry.tag    = tag;
    assign new_entry.points = points;
    assign new_entry.time_s = time_s;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                sst_cell u_cell (
                    .clk           (clk),
                    .rst_n         (rst_n),
                    .load          (load),
                    .new_entry     (new_entry),
                    .left_entry    (new_entry),
                    .left_outranks (1'b1),
                    .entry         (cell_entry[gi]),
                    .outranks      (cell_out[gi])
                );
                assign hot[gi] = !cell_out[gi];
            end
            else
            begin : g_body
                sst_cell u_cell (
                    .clk           (clk),
                    .rst_n         (rst_n),
                    .load          (load),
                    .new_entry     (new_entry),
                    .left_entry    (cell_entry[gi-1]),
                    .left_outranks (cell_out[gi-1]),
                    .entry         (cell_entry[gi]),
                    .outranks      (cell_out[gi])
                );
                assign hot[gi] = !cell_out[gi] && cell_out[gi-1];
            end
            assign cell_vld[gi] = cell_entry[gi].valid;
        end
    endgenerate

    assign hot[TABLE_DEPTH] = cell_out[TABLE_DEPTH-1];

    // one-hot insert point to index
    always_comb
    begin
        idx = '0;
        for (int i = 0; i <= TABLE_DEPTH; i++)
        begin
            if (hot_reg[i])
            begin
                idx = idx | IDX_W'(i);
            end
        end
        rank_next = RANK_W'(idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= load;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hot_reg     <= hot;
        full_reg    <= cell_vld[TABLE_DEPTH-1];
        rank_reg    <= rank_next;
        dropped_reg <= full_reg;
    end

    assign done    = done_reg;
    assign rank    = rank_reg;
    assign dropped = dropped_reg;

`ifndef SYNTH
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s1_valid_reg))
        else $error("result strobe without a word two cycles before");

    a_hot_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot(hot_reg))
        else $error("insert point not one-hot");

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (((TABLE_DEPTH+1)'(cell_vld) + 1'b1) & (TABLE_DEPTH+1)'(cell_vld)) == '0)
        else $error("valid entries do not form a prefix");

    a_fill_one: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(cell_vld))
        else $error("table changed without an insert");
`endif

endmodule

// ----- verif/sst_checker.sv -----
`timescale 1ns / 100ps

module sst_checker
    import sst_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [TAG_W-1:0]    tag,
    input  logic [POINTS_W-1:0] points,
    input  logic [TIME_W-1:0]   time_s,
    input  logic                done,
    input  logic [RANK_W-1:0]   rank,
    input  logic                dropped,
    output int                  errors,
    output int                  outstanding,
    output int                  words,
    output int                  placed,
    output int                  top_placed,
    output int                  new_dropped,
    output int                  old_pushed,
    output int                  ties
);

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              dropped;
    } score_result_t;

    score_result_t pending_results[$];
    sst_entry_t    board[TABLE_DEPTH];

    // Insert one word into the shadow table and return the rank/dropped it yields.
    function automatic score_result_t insert_entry(
        input logic [TAG_W-1:0]    new_tag,
        input logic [POINTS_W-1:0] new_points,
        input logic [TIME_W-1:0]   new_time
    );
        int            slot;
        int            pos;
        bit            tied;
        score_result_t res;
        pos  = 0;
        tied = 1'b0;
        for (slot = 0; slot < TABLE_DEPTH; slot++)
        begin
            if (board[slot].valid)
            begin
                if (board[slot].points > new_points ||
                    (board[slot].points == new_points && board[slot].time_s < new_time))
                    pos++;
                if (board[slot].points == new_points && board[slot].time_s == new_time)
                    tied = 1'b1;
            end
        end
        res.dropped = board[TABLE_DEPTH-1].valid;
        if (pos < TABLE_DEPTH)
        begin
            for (slot = TABLE_DEPTH - 1; slot > pos; slot--)
                board[slot] = board[slot-1];
            board[pos] = '{valid: 1'b1, tag: new_tag, points: new_points, time_s: new_time};
            placed++;
            if (pos == 0)
                top_placed++;
            if (res.dropped)
                old_pushed++;
        end
        else
        begin
            new_dropped++;
        end
        if (tied)
            ties++;
        res.rank = RANK_W'(pos);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        score_result_t exp_res;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                board[i] = '0;
            pending_results.delete();
            errors      = 0;
            outstanding = 0;
            words       = 0;
            placed      = 0;
            top_placed  = 0;
            new_dropped = 0;
            old_pushed  = 0;
            ties        = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no word pending: rank %0d dropped %0d",
                             $time, rank, dropped);
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (rank !== exp_res.rank)
                    begin
                        errors++;
                        $display("%0t: rank mismatch: expected %0d actual %0d",
                                 $time, exp_res.rank, rank);
                    end
                    if (dropped !== exp_res.dropped)
                    begin
                        errors++;
                        $display("%0t: dropped mismatch: expected %0d actual %0d",
                                 $time, exp_res.dropped, dropped);
                    end
                end
            end
            if (start && !busy)
            begin
                pending_results.push_back(insert_entry(tag, points, time_s));
                words++;
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// ----- verif/tb_sorted_score_table_insert.sv -----
`timescale 1ns / 100ps

module tb_sorted_score_table_insert;
    import sst_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_WORDS = 1200;
    localparam int CYCLE_LIMIT  = 300000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [TAG_W-1:0]    tag;
    logic [POINTS_W-1:0] points;
    logic [TIME_W-1:0]   time_s;
    logic                done;
    logic [RANK_W-1:0]   rank;
    logic                dropped;

    int errors;
    int outstanding;
    int words;
    int placed;
    int top_placed;
    int new_dropped;
    int old_pushed;
    int ties;
    int cycle_count = 0;

    logic [POINTS_W-1:0] recent_points[16];
    logic [TIME_W-1:0]   recent_time[16];
    int                  recent_idx = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_score_table_insert #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .tag     (tag),
        .points  (points),
        .time_s  (time_s),
        .done    (done),
        .rank    (rank),
        .dropped (dropped)
    );

    sst_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .tag         (tag),
        .points      (points),
        .time_s      (time_s),
        .done        (done),
        .rank        (rank),
        .dropped     (dropped),
        .errors      (errors),
        .outstanding (outstanding),
        .words       (words),
        .placed      (placed),
        .top_placed  (top_placed),
        .new_dropped (new_dropped),
        .old_pushed  (old_pushed),
        .ties        (ties)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("FAIL");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the word was taken.
    task automatic send_word(
        input logic [TAG_W-1:0]    w_tag,
        input logic [POINTS_W-1:0] w_points,
        input logic [TIME_W-1:0]   w_time
    );
        bit taken;
        start  <= 1'b1;
        tag    <= w_tag;
        points <= w_points;
        time_s <= w_time;
        recent_points[recent_idx] = w_points;
        recent_time[recent_idx]   = w_time;
        recent_idx = (recent_idx + 1) % 16;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic idle_gap();
        int gap;
        if ($urandom_range(0, 99) < 55)
            gap = 0;
        else if ($urandom_range(0, 99) < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [POINTS_W-1:0] p;
        logic [TIME_W-1:0]   t;
        int                  pick;
        int                  burst;

        rst_n  = 1'b0;
        start  = 1'b0;
        tag    = '0;
        points = '0;
        time_s = '0;
        for (int i = 0; i < 16; i++)
        begin
            recent_points[i] = '0;
            recent_time[i]   = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, key extremes, ties at middle and top, fill,
        // full-table placement and full-table rejection
        send_word(32'h4142_4344, 16'd100, 16'd50);
        send_word(32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
        send_word(32'h0000_0000, 16'd1, 16'hFFFF);
        send_word(32'h5A5A_5A5A, 16'd100, 16'd50);
        send_word(32'hA5A5_A5A5, 16'hFFFF, 16'h0000);
        send_word(32'h1234_5678, 16'd100, 16'd49);
        for (int i = 1; i <= 10; i++)
        begin
            idle_gap();
            send_word($urandom, 16'(i * 1000), 16'(i));
        end
        send_word(32'h7777_7777, 16'd0, 16'hFFFF);
        send_word(32'h8888_8888, 16'd0, 16'h0000);
        send_word(32'h9999_9999, 16'd1, 16'hFFFF);
        send_word(32'hCAFE_0001, 16'hFFFF, 16'h0000);
        send_word(32'h0101_0101, 16'd5000, 16'd5);

        // random: bursts biased toward ties and near-top keys so that
        // placement keeps happening on a full table
        burst = 0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (burst == 0)
            begin
                idle_gap();
                burst = $urandom_range(0, 99) < 10 ? $urandom_range(5, 30) : 0;
            end
            else
            begin
                burst--;
            end
            pick = $urandom_range(0, 3);
            case (pick)
                0:
                begin
                    p = POINTS_W'($urandom);
                    t = TIME_W'($urandom);
                end
                1:
                begin
                    p = recent_points[$urandom_range(0, 15)];
                    t = recent_time[$urandom_range(0, 15)];
                    if ($urandom_range(0, 1))
                        t = recent_time[(recent_idx + 15) % 16];
                end
                2:
                begin
                    p = 16'hFFFF - 16'($urandom_range(0, 3));
                    t = TIME_W'($urandom_range(0, 7));
                end
                default:
                begin
                    p = POINTS_W'($urandom_range(0, 3));
                    t = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 7));
                end
            endcase
            send_word($urandom, p, t);
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        $display("%0d words: %0d placed (%0d at the top), %0d new words rejected",
                 words, placed, top_placed, new_dropped);
        $display("%0d old entries pushed out, %0d inserts tied with a stored entry",
                 old_pushed, ties);
        if (errors == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sst_pkg.sv
rtl/sst_cell.sv
rtl/sorted_score_table_insert.sv
verif/sst_checker.sv
verif/tb_sorted_score_table_insert.sv
